/* sv/sfs_pkg.sv */
// Shared types, constants and arithmetic helpers for the separable FIR smoother.
package sfs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 256;
  localparam int MAX_TAPS = 4;

  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LOAD_W   = ADDR_W + 1;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 64;
  localparam int TAPS_W   = 3;
  localparam int LEN_W    = 9;
  localparam int CNT_W    = 7;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 8;
  localparam int ACC_W    = 36;
  localparam int PROD_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COEFFS    = 3'd0,
    CFG_COLUMN_COEFFS = 3'd1,
    CFG_ROW_TAPS      = 3'd2,
    CFG_COLUMN_TAPS   = 3'd3,
    CFG_ROW_LENGTH    = 3'd4,
    CFG_ROW_COUNT     = 3'd5,
    CFG_SMOOTH_ZERO   = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Clamp a tap count to the range 1 .. MAX_TAPS.
  function automatic logic [TAPS_W-1:0] clamp_taps(input logic [TAPS_W-1:0] n);
    logic [TAPS_W-1:0] v;
    v = n;
    if (n == '0) v = TAPS_W'(1);
    else if (n > TAPS_W'(MAX_TAPS)) v = TAPS_W'(MAX_TAPS);
    return v;
  endfunction

  // Offset of tap idx in a centred kernel of n taps: n/2 - n + 1 + idx.
  function automatic logic signed [3:0] tap_off(input logic [TAPS_W-1:0] n,
                                                input logic [1:0] idx);
    logic signed [3:0] v;
    v = $signed({2'b00, n[2:1]}) - $signed({1'b0, n}) + 4'sd1 + $signed({2'b00, idx});
    return v;
  endfunction

  // Round half up after a Q2.14 product sum and saturate to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [SAMPLE_W-1:0] v;
    t = (acc + ACC_W'(8192)) >>> 14;
    if (t > ACC_W'(32767)) v = 16'sh7fff;
    else if (t < -ACC_W'(32768)) v = 16'sh8000;
    else v = t[SAMPLE_W-1:0];
    return v;
  endfunction

endpackage

/* sv/sfs_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module sfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/separable_fir_smoother_unit.sv */
// Separable 2D FIR smoother: frame store, position tracking and shared MAC pipeline.
//
// Usage. The input stream carries items of two kinds, chosen by in_tuser[0]: a load
// (0) writes in_tdata as the next sample of the frame in row-major order, and a fetch
// (1) returns the next smoothed sample on the output stream. in_tuser[1] marks a
// segment-zero frame; the value given with the load that completes the frame is kept.
// Loads give no result. A fetch before the frame is complete returns zero with
// out_tuser set. The fetch that returns out_tlast starts a new frame.
// A fetch issues row_taps * column_taps frame-store reads, or row_taps alone for an
// unsmoothed segment-zero frame, one per cycle through the single read port and the
// shared multiply-accumulate, then passes the pipeline and the output register. The
// first fetch after a configuration write, unless it wraps to the frame start, also
// runs a radix-2 division to find its row and column. in_tready is high while no item
// is in progress; only one item is worked on at a time. A result waiting on a stalled
// receiver holds in the output register; loads are still taken meanwhile, and a later
// fetch waits once its result is ready. Reset (synchronous, rst_n low) sets the
// configuration and control registers to their defaults and empties the frame; the
// frame store itself is not cleared.
module separable_fir_smoother_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream: tdata = sample[15:0]; tuser = opcode[0], segment_is_zero[1].
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sfs_pkg::SAMPLE_W-1:0]      in_tdata,
  input  logic [1:0]                        in_tuser,
  // Result stream: tdata = smoothed[15:0]; tuser = not_ready[0].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sfs_pkg::SAMPLE_W-1:0]      out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfs_pkg::COEF_W-1:0]        cfg_wdata
);

  import sfs_pkg::*;

  // Configuration registers.
  logic [COEF_W-1:0] row_coeffs_r, col_coeffs_r;
  logic [TAPS_W-1:0] row_taps_r, col_taps_r;
  logic [LEN_W-1:0]  row_len_r;
  logic [CNT_W-1:0]  row_cnt_r;
  logic              smooth_zero_r;

  // Control and position state.
  state_t            state_r, state_nxt;
  logic [LOAD_W-1:0] lp_r;
  logic [ADDR_W-1:0] fp_r;
  logic [ROW_W-1:0]  pr_r;
  logic [COL_W-1:0]  pc_r;
  logic              dirty_r;
  logic              segz_r;
  logic              axial_r;
  logic [TAPS_W-1:0] nce_r;

  // Row/column divider.
  logic [3:0]        div_cnt_r;
  logic [ADDR_W-1:0] div_dvd_r;
  logic [COL_W-1:0]  div_rem_r, div_rem_nxt;
  logic [ROW_W-1:0]  div_quo_r, div_quo_nxt;
  logic [LEN_W-1:0]  div_t;
  logic              div_ge;

  // Read issue.
  logic              iss_on_r;
  logic [1:0]        iss_k_r, iss_j_r;

  // Pipeline stages.
  logic                       a_valid_r, a_mask_r, a_lastj_r, a_lastk_r, a_kval_r;
  logic signed [SAMPLE_W-1:0] a_tap_r, a_ctap_r;
  logic signed [ACC_W-1:0]    acc1_r, acc2_r;
  logic                       b_valid_r, b_kval_r, b_lastk_r;
  logic signed [ACC_W-1:0]    b_sum_r;
  logic signed [SAMPLE_W-1:0] b_ctap_r;
  logic                       c_valid_r, c_kval_r, c_lastk_r;
  logic signed [SAMPLE_W-1:0] c_rv_r, c_ctap_r;

  // Pending result and output register.
  logic [SAMPLE_W-1:0] res_smooth_r;
  logic                res_last_r, res_nr_r;
  logic                out_tvalid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_last_r, out_nr_r;

  // Derived frame geometry.
  logic [TAPS_W-1:0]   n_row, n_col;
  logic [CNT_W-1:0]    rows;
  logic [LEN_W-1:0]    cols;
  logic [15:0]         size_w;
  logic [LOAD_W-1:0]   size;
  logic                frame_full;
  logic                fetch_wrap;
  logic                fetch_last;

  // Input handshake.
  logic                in_acc, in_fetch, in_load;
  logic [LOAD_W-1:0]   lp_eff, lp_inc;

  // Issue datapath.
  logic signed [3:0]   offk, offj;
  logic signed [7:0]   rr;
  logic signed [9:0]   sc;
  logic signed [16:0]  kc, addr_s;
  logic                kval, jval;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                ram_we;

  // Arithmetic.
  logic signed [PROD_W-1:0]   prod1, prod2;
  logic signed [ACC_W-1:0]    sum1, sum2;
  logic signed [SAMPLE_W-1:0] rv_b, fin_d;
  logic                       res_now;
  logic [SAMPLE_W-1:0]        res_val;
  logic                       out_free;

  assign n_row  = clamp_taps(row_taps_r);
  assign n_col  = clamp_taps(col_taps_r);
  assign rows   = (row_cnt_r == '0) ? CNT_W'(1) :
                  (row_cnt_r > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_cnt_r;
  assign cols   = (row_len_r == '0) ? LEN_W'(1) :
                  (row_len_r > LEN_W'(MAX_COLS)) ? LEN_W'(MAX_COLS) : row_len_r;
  assign size_w = 16'(rows) * 16'(cols);
  assign size   = size_w[LOAD_W-1:0];

  assign frame_full = (lp_r >= size);
  assign fetch_wrap = (LOAD_W'(fp_r) >= size);
  assign fetch_last = (LOAD_W'(fp_r) == size - LOAD_W'(1));

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_load   = in_acc && !in_tuser[0];
  assign in_fetch  = in_acc && in_tuser[0];
  assign lp_eff    = frame_full ? '0 : lp_r;
  assign lp_inc    = lp_eff + LOAD_W'(1);

  // Divider step: one quotient bit per cycle.
  assign div_t  = {div_rem_r, div_dvd_r[ADDR_W-1]};
  assign div_ge = (div_t >= cols);
  always_comb begin
    div_rem_nxt = div_ge ? COL_W'(div_t - cols) : div_t[COL_W-1:0];
    div_quo_nxt = {div_quo_r[ROW_W-2:0], div_ge};
  end

  // Address of tap (k, j): fp - offk*cols - offj, valid only inside the frame.
  always_comb begin
    offk   = axial_r ? tap_off(nce_r, iss_k_r) : 4'sd0;
    offj   = tap_off(n_row, iss_j_r);
    rr     = $signed({2'b00, pr_r}) - 8'(offk);
    sc     = $signed({2'b00, pc_r}) - 10'(offj);
    kval   = !rr[7] && (rr[CNT_W-1:0] < rows);
    jval   = !sc[9] && (sc[LEN_W-1:0] < cols);
    kc     = 17'(offk) * 17'($signed({1'b0, cols}));
    addr_s = $signed({3'b000, fp_r}) - kc - 17'(offj);
  end

  assign ram_we   = in_load;
  assign ram_addr = (state_r == ST_IDLE) ? lp_eff[ADDR_W-1:0] : addr_s[ADDR_W-1:0];

  sfs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata),
    .rdata (ram_rdata)
  );

  // Row pass MAC, then the column pass MAC on the rounded row values.
  always_comb begin
    prod1 = a_mask_r ? PROD_W'(a_tap_r) * PROD_W'($signed(ram_rdata)) : '0;
    sum1  = acc1_r + ACC_W'(prod1);
    rv_b  = round_sat(b_sum_r);
    prod2 = c_kval_r ? PROD_W'(c_ctap_r) * PROD_W'(c_rv_r) : '0;
    sum2  = acc2_r + ACC_W'(prod2);
    fin_d = round_sat(sum2);
  end

  // A result leaves the pipeline either after the row pass alone or after both passes.
  always_comb begin
    res_now = 1'b0;
    res_val = '0;
    if (state_r == ST_RUN) begin
      if (!axial_r && b_valid_r) begin
        res_now = 1'b1;
        res_val = rv_b;
      end else if (axial_r && c_valid_r && c_lastk_r) begin
        res_now = 1'b1;
        res_val = fin_d;
      end
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fetch) begin
          if (!frame_full) state_nxt = ST_DONE;
          else if (!fetch_wrap && dirty_r) state_nxt = ST_DIV;
          else state_nxt = ST_RUN;
        end
      end
      ST_DIV:  if (div_cnt_r == '0) state_nxt = ST_RUN;
      ST_RUN:  if (res_now) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_coeffs_r  <= COEF_W'(16384);
      col_coeffs_r  <= COEF_W'(16384);
      row_taps_r    <= TAPS_W'(1);
      col_taps_r    <= TAPS_W'(1);
      row_len_r     <= LEN_W'(MAX_COLS);
      row_cnt_r     <= CNT_W'(MAX_ROWS);
      smooth_zero_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_COEFFS:    row_coeffs_r  <= cfg_wdata;
        CFG_COLUMN_COEFFS: col_coeffs_r  <= cfg_wdata;
        CFG_ROW_TAPS:      row_taps_r    <= cfg_wdata[TAPS_W-1:0];
        CFG_COLUMN_TAPS:   col_taps_r    <= cfg_wdata[TAPS_W-1:0];
        CFG_ROW_LENGTH:    row_len_r     <= cfg_wdata[LEN_W-1:0];
        CFG_ROW_COUNT:     row_cnt_r     <= cfg_wdata[CNT_W-1:0];
        CFG_SMOOTH_ZERO:   smooth_zero_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Control, positions and issue sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lp_r         <= '0;
      fp_r         <= '0;
      pr_r         <= '0;
      pc_r         <= '0;
      dirty_r      <= 1'b0;
      segz_r       <= 1'b0;
      iss_on_r     <= 1'b0;
      iss_k_r      <= '0;
      iss_j_r      <= '0;
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      c_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // The row and column counters follow fp only while the geometry is unchanged.
      if (cfg_we) dirty_r <= 1'b1;

      if (in_load) begin
        lp_r <= lp_inc;
        if (frame_full) begin
          fp_r    <= '0;
          pr_r    <= '0;
          pc_r    <= '0;
          dirty_r <= 1'b0;
        end
        if (lp_inc == size) segz_r <= in_tuser[1];
      end

      if (in_fetch && frame_full) begin
        if (fetch_wrap) begin
          fp_r    <= '0;
          pr_r    <= '0;
          pc_r    <= '0;
          dirty_r <= 1'b0;
        end
        if (fetch_wrap || !dirty_r) begin
          iss_on_r <= 1'b1;
          iss_k_r  <= '0;
          iss_j_r  <= '0;
        end
      end

      if (state_r == ST_DIV && div_cnt_r == '0) begin
        pr_r     <= div_quo_nxt;
        pc_r     <= div_rem_nxt;
        dirty_r  <= 1'b0;
        iss_on_r <= 1'b1;
        iss_k_r  <= '0;
        iss_j_r  <= '0;
      end

      if (state_r == ST_RUN && iss_on_r) begin
        if (iss_j_r == 2'(n_row - TAPS_W'(1))) begin
          iss_j_r <= '0;
          if (iss_k_r == 2'(nce_r - TAPS_W'(1))) iss_on_r <= 1'b0;
          else iss_k_r <= iss_k_r + 2'd1;
        end else begin
          iss_j_r <= iss_j_r + 2'd1;
        end
      end

      a_valid_r <= (state_r == ST_RUN) && iss_on_r;
      b_valid_r <= a_valid_r && a_lastj_r;
      c_valid_r <= axial_r && b_valid_r;

      if (res_now) begin
        if (fetch_last) begin
          fp_r <= '0;
          lp_r <= '0;
          pr_r <= '0;
          pc_r <= '0;
        end else begin
          fp_r <= fp_r + ADDR_W'(1);
          if (LEN_W'(pc_r) == cols - LEN_W'(1)) begin
            pc_r <= '0;
            pr_r <= pr_r + ROW_W'(1);
          end else begin
            pc_r <= pc_r + COL_W'(1);
          end
        end
      end

      if (state_r == ST_DONE && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Datapath registers: divider, MAC stages and result holding.
  always_ff @(posedge clk) begin
    if (in_fetch) begin
      axial_r   <= !segz_r || smooth_zero_r;
      nce_r     <= (!segz_r || smooth_zero_r) ? n_col : TAPS_W'(1);
      acc1_r    <= '0;
      acc2_r    <= '0;
      div_cnt_r <= 4'(ADDR_W - 1);
      div_dvd_r <= fp_r;
      div_rem_r <= '0;
      div_quo_r <= '0;
      if (!frame_full) begin
        res_smooth_r <= '0;
        res_last_r   <= 1'b0;
        res_nr_r     <= 1'b1;
      end
    end

    if (state_r == ST_DIV) begin
      div_cnt_r <= div_cnt_r - 4'd1;
      div_dvd_r <= {div_dvd_r[ADDR_W-2:0], 1'b0};
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
    end

    a_mask_r  <= kval && jval;
    a_tap_r   <= $signed(row_coeffs_r[16*iss_j_r +: SAMPLE_W]);
    a_ctap_r  <= $signed(col_coeffs_r[16*iss_k_r +: SAMPLE_W]);
    a_lastj_r <= (iss_j_r == 2'(n_row - TAPS_W'(1)));
    a_lastk_r <= (iss_k_r == 2'(nce_r - TAPS_W'(1)));
    a_kval_r  <= kval;

    if (a_valid_r) begin
      if (a_lastj_r) begin
        b_sum_r   <= sum1;
        b_kval_r  <= a_kval_r;
        b_ctap_r  <= a_ctap_r;
        b_lastk_r <= a_lastk_r;
        acc1_r    <= '0;
      end else begin
        acc1_r <= sum1;
      end
    end

    c_rv_r    <= rv_b;
    c_kval_r  <= b_kval_r;
    c_ctap_r  <= b_ctap_r;
    c_lastk_r <= b_lastk_r;

    if (c_valid_r) begin
      acc2_r <= c_lastk_r ? '0 : sum2;
    end

    if (res_now) begin
      res_smooth_r <= res_val;
      res_last_r   <= fetch_last;
      res_nr_r     <= 1'b0;
    end

    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_smooth_r;
      out_last_r <= res_last_r;
      out_nr_r   <= res_nr_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_nr_r;

endmodule
